FILE: hdl/b64_pkg.sv
// Shared types, constants and alphabet functions for the Base64 codec.
// No dependencies; every other file of the codec but b64_checker.sv imports this package.
package b64_pkg;

    localparam int MAX_RESULTS = 4;
    localparam int CNT_W       = $clog2(MAX_RESULTS + 1);

    localparam logic [7:0] CHAR_PAD   = 8'h3D;  // '='
    localparam logic [7:0] CHAR_PLUS  = 8'h2B;  // '+'
    localparam logic [7:0] CHAR_SLASH = 8'h2F;  // '/'
    localparam logic [7:0] CHAR_UPPER = 8'h41;  // 'A'
    localparam logic [7:0] CHAR_LOWER = 8'h61;  // 'a'
    localparam logic [7:0] CHAR_DIGIT = 8'h30;  // '0'

    localparam logic DIR_ENCODE = 1'b0;
    localparam logic DIR_DECODE = 1'b1;

    typedef struct packed {
        logic [7:0] data;
        logic       err;
        logic       last;
    } out_word_t;

    typedef struct packed {
        logic                  load;
        logic [CNT_W-1:0]      count;
        out_word_t [MAX_RESULTS-1:0] words;
    } res_group_t;

    typedef struct packed {
        logic       valid;
        logic [5:0] value;
    } dec_val_t;

    // Map a six-bit value to its alphabet character.
    function automatic logic [7:0] enc_char(input logic [5:0] v);
        logic [7:0] r;
        if (v < 6'd26) begin
            r = CHAR_UPPER + 8'(v);
        end else if (v < 6'd52) begin
            r = CHAR_LOWER + 8'(v - 6'd26);
        end else if (v < 6'd62) begin
            r = CHAR_DIGIT + 8'(v - 6'd52);
        end else if (v == 6'd62) begin
            r = CHAR_PLUS;
        end else begin
            r = CHAR_SLASH;
        end
        return r;
    endfunction

    // Map a character back to its six-bit value; valid is low outside the alphabet.
    function automatic dec_val_t dec_char(input logic [7:0] c);
        dec_val_t r;
        r.valid = 1'b1;
        r.value = 6'd0;
        if (c >= CHAR_UPPER && c <= 8'h5A) begin
            r.value = 6'(c - CHAR_UPPER);
        end else if (c >= CHAR_LOWER && c <= 8'h7A) begin
            r.value = 6'(c - CHAR_LOWER) + 6'd26;
        end else if (c >= CHAR_DIGIT && c <= 8'h39) begin
            r.value = 6'(c - CHAR_DIGIT) + 6'd52;
        end else if (c == CHAR_PLUS) begin
            r.value = 6'd62;
        end else if (c == CHAR_SLASH) begin
            r.value = 6'd63;
        end else begin
            r.valid = 1'b0;
        end
        return r;
    endfunction

endpackage

FILE: hdl/base64_codec_unit.sv
// Top level of the streaming Base64 codec (standard alphabet, '=' padding).
// Instantiates b64_core and b64_out_buf; types come from b64_pkg.
//
//   channel   ports                                        direction
//   -------   ------------------------------------------   ---------
//   input     s_valid s_ready s_data_in s_end_of_stream    in
//   result    m_valid m_ready m_data_out m_error_flag       out
//             m_last_of_run
//   config    cfg_valid cfg_ready cfg_direction            in
//
// An accepted word waits in the input register and is processed there once the result
// buffer can take its results; these are registered in the buffer and shown on m_*, one
// word per cycle while m_ready is high. Encoding is result channel bound (three input words
// give four results); decoding likewise takes one word per cycle. The four-word buffer sets the limit.
// Reset: synchronous, active low; clears the held word, the group, discard flag, direction and buffer count.
// Stalls: while the buffer drains, one more word is taken into the input register;
// a word that produces no result is processed without waiting for the buffer.
module base64_codec_unit (
    input  logic       aclk,
    input  logic       aresetn,
    // input words
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_data_in,
    input  logic       s_end_of_stream,
    // result words
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_data_out,
    output logic       m_error_flag,
    output logic       m_last_of_run,
    // direction register write
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic       cfg_direction
);
    import b64_pkg::*;

    res_group_t grp;
    logic       out_free;

    // always take a direction write; writes only come while the block is idle is a rule for the user, not enforced here
    assign cfg_ready = 1'b1;

    // hold state, gather the group and build its result words
    b64_core u_core (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_data_in       (s_data_in),
        .s_end_of_stream (s_end_of_stream),
        .cfg_valid       (cfg_valid),
        .cfg_direction   (cfg_direction),
        .out_free        (out_free),
        .grp             (grp)
    );

    // drain the finished group one word per cycle while m_ready is high
    b64_out_buf u_out (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .grp           (grp),
        .out_free      (out_free),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_data_out    (m_data_out),
        .m_error_flag  (m_error_flag),
        .m_last_of_run (m_last_of_run)
    );

endmodule

FILE: hdl/b64_core.sv
// Input register, group state and per-word encode/decode logic of the codec.
// Depends on b64_pkg; hands finished result groups to b64_out_buf.
module b64_core (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [7:0]         s_data_in,
    input  logic               s_end_of_stream,
    input  logic               cfg_valid,
    input  logic               cfg_direction,
    input  logic               out_free,
    output b64_pkg::res_group_t grp
);
    import b64_pkg::*;

    logic        in_valid_reg, in_valid_next;
    logic [7:0]  in_data_reg;
    logic        in_eos_reg;
    logic        dir_reg;
    logic [23:0] group_reg, group_next;
    logic [1:0]  fill_reg, fill_next;
    logic [1:0]  pad_reg, pad_next;
    logic        disc_reg, disc_next;

    logic        fire;
    logic        s_fire;
    res_group_t  res;

    always_comb begin
        logic [1:0]  fe;
        logic [2:0]  f1;
        logic [23:0] gnew;
        logic [1:0]  pnew;
        logic [1:0]  nbytes;
        logic        is_pad;
        logic        bad;
        dec_val_t    dv;

        fe     = (fill_reg == 2'd3) ? 2'd2 : fill_reg;
        f1     = 3'd0;
        gnew   = group_reg;
        pnew   = pad_reg;
        nbytes = 2'd0;
        is_pad = (in_data_reg == CHAR_PAD);
        bad    = 1'b0;
        dv     = dec_char(in_data_reg);

        group_next = group_reg;
        fill_next  = fill_reg;
        pad_next   = pad_reg;
        disc_next  = disc_reg;
        res.load   = 1'b0;
        res.count  = '0;
        res.words  = '0;

        if (disc_reg) begin
            // drop the word; a stream end closes the discard run
            if (in_eos_reg) begin
                disc_next = 1'b0;
            end
        end else if (dir_reg == DIR_ENCODE) begin
            unique case (fe)
                2'd0:    gnew = group_reg | {in_data_reg, 16'h0000};
                2'd1:    gnew = group_reg | {8'h00, in_data_reg, 8'h00};
                default: gnew = group_reg | {16'h0000, in_data_reg};
            endcase
            f1 = 3'(fe) + 3'd1;
            if (f1 < 3'd3 && !in_eos_reg) begin
                group_next = gnew;
                fill_next  = f1[1:0];
            end else begin
                res.count = CNT_W'(MAX_RESULTS);
                for (int k = 0; k < MAX_RESULTS; k++) begin
                    res.words[k].data = (3'(k) <= f1) ? enc_char(gnew[6'(23 - 6*k) -: 6])
                                                      : CHAR_PAD;
                    res.words[k].err  = 1'b0;
                    res.words[k].last = (k == MAX_RESULTS - 1);
                end
                group_next = '0;
                fill_next  = '0;
                pad_next   = '0;
            end
        end else begin
            if (is_pad) begin
                bad  = (fill_reg < 2'd2);
                pnew = pad_reg + 2'd1;
                gnew = {group_reg[17:0], 6'd0};
            end else begin
                bad  = !dv.valid || (pad_reg != 2'd0);
                gnew = {group_reg[17:0], dv.value};
            end
            if (!bad) begin
                if (fill_reg != 2'd3) begin
                    // stream ending mid-group is an error
                    bad        = in_eos_reg;
                    group_next = gnew;
                    fill_next  = fill_reg + 2'd1;
                    pad_next   = pnew;
                end else if (pnew != 2'd0 && !in_eos_reg) begin
                    bad = 1'b1;
                end else begin
                    nbytes    = 2'd3 - pnew;
                    res.count = CNT_W'(nbytes);
                    res.words[0].data = gnew[23:16];
                    res.words[1].data = gnew[15:8];
                    res.words[2].data = gnew[7:0];
                    res.words[0].last = (nbytes == 2'd1);
                    res.words[1].last = (nbytes == 2'd2);
                    res.words[2].last = (nbytes == 2'd3);
                    group_next = '0;
                    fill_next  = '0;
                    pad_next   = '0;
                end
            end
            if (bad) begin
                res.count         = CNT_W'(1);
                res.words         = '0;
                res.words[0].err  = 1'b1;
                res.words[0].last = 1'b1;
                group_next        = '0;
                fill_next         = '0;
                pad_next          = '0;
                disc_next         = !in_eos_reg;
            end
        end
    end

    // process the held word at once if it gives no result, else once the result buffer can take its group
    assign fire     = in_valid_reg && (res.count == '0 || out_free);
    assign s_ready  = !in_valid_reg || fire;
    assign s_fire   = s_valid && s_ready;
    assign in_valid_next = s_fire ? 1'b1 : (fire ? 1'b0 : in_valid_reg);

    always_comb begin
        grp      = res;
        grp.load = fire && (res.count != '0);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            dir_reg      <= DIR_ENCODE;
            group_reg    <= '0;
            fill_reg     <= '0;
            pad_reg      <= '0;
            disc_reg     <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
            if (cfg_valid) begin
                dir_reg   <= cfg_direction;
                group_reg <= '0;
                fill_reg  <= '0;
                pad_reg   <= '0;
                disc_reg  <= 1'b0;
            end else if (fire) begin
                group_reg <= group_next;
                fill_reg  <= fill_next;
                pad_reg   <= pad_next;
                disc_reg  <= disc_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            in_data_reg <= s_data_in;
            in_eos_reg  <= s_end_of_stream;
        end
    end

endmodule

FILE: hdl/b64_out_buf.sv
// Result buffer: holds one group of up to four words and shifts them out.
// Depends on b64_pkg; fed by b64_core.
module b64_out_buf (
    input  logic               aclk,
    input  logic               aresetn,
    input  b64_pkg::res_group_t grp,
    output logic               out_free,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [7:0]         m_data_out,
    output logic               m_error_flag,
    output logic               m_last_of_run
);
    import b64_pkg::*;

    out_word_t [MAX_RESULTS-1:0] words_reg, words_next;
    logic [CNT_W-1:0]            cnt_reg, cnt_next;
    logic                        pop;

    assign m_valid  = (cnt_reg != '0);
    assign pop      = m_valid && m_ready;
    assign out_free = (cnt_reg == '0) || (cnt_reg == CNT_W'(1) && m_ready);

    assign m_data_out    = words_reg[0].data;
    assign m_error_flag  = words_reg[0].err;
    assign m_last_of_run = words_reg[0].last;

    always_comb begin
        words_next = words_reg;
        cnt_next   = cnt_reg;
        if (grp.load) begin
            words_next = grp.words;
            cnt_next   = grp.count;
        end else if (pop) begin
            for (int i = 0; i < MAX_RESULTS - 1; i++) begin
                words_next[i] = words_reg[i+1];
            end
            words_next[MAX_RESULTS-1] = '0;
            cnt_next = cnt_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        words_reg <= words_next;
    end

endmodule

FILE: hdl/b64_checker.sv
// Port-level checks for the Base64 codec, bound to base64_codec_unit.
// Depends only on the top level's ports.
module b64_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       m_valid,
    input logic       m_ready,
    input logic [7:0] m_data_out,
    input logic       m_error_flag,
    input logic       m_last_of_run
);

    // hold a stalled result word
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data_out)
            && $stable(m_error_flag) && $stable(m_last_of_run))
        else $error("result word changed while stalled");

    // an error word carries zero data and closes its run
    a_err_word: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_error_flag |-> m_data_out == 8'h00 && m_last_of_run)
        else $error("malformed error word");

    // the words of one run follow without gaps
    a_run_gapless: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_last_of_run |=> m_valid)
        else $error("gap inside a result run");

    // nothing is shown right after reset
    a_reset_quiet: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

endmodule

bind base64_codec_unit b64_checker u_b64_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .m_valid       (m_valid),
    .m_ready       (m_ready),
    .m_data_out    (m_data_out),
    .m_error_flag  (m_error_flag),
    .m_last_of_run (m_last_of_run)
);
